>>> rtl/core/chsh_pkg.sv
// chsh_pkg: shared types and codes for the convex hull support block
// no dependencies
`default_nettype none
package chsh_pkg;
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_SUPPORT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_LINK_CNT,
        S_LINK_SCAN,
        S_LINK_DONE,
        S_Q_START,
        S_Q_CNT,
        S_Q_NBR,
        S_Q_POS,
        S_Q_MUL,
        S_Q_CMP,
        S_Q_PASS,
        S_Q_OUT,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

>>> rtl/core/chsh_dot.sv
// chsh_dot: three-term dot product summed from registered products
// depends on nothing outside this file
`default_nettype none
module chsh_dot #(
    parameter int CW = 16
) (
    input  wire logic                  clk,
    input  wire logic signed [CW-1:0]  px,
    input  wire logic signed [CW-1:0]  py,
    input  wire logic signed [CW-1:0]  pz,
    input  wire logic signed [CW-1:0]  dx,
    input  wire logic signed [CW-1:0]  dy,
    input  wire logic signed [CW-1:0]  dz,
    output logic signed [2*CW+1:0]     dot
);
    logic signed [2*CW-1:0] mx_reg, my_reg, mz_reg;

    always_ff @(posedge clk)
    begin
        mx_reg <= px * dx;
        my_reg <= py * dy;
        mz_reg <= pz * dz;
    end

    assign dot = (2*CW+2)'(mx_reg) + (2*CW+2)'(my_reg) + (2*CW+2)'(mz_reg);
endmodule
`default_nettype wire

>>> rtl/core/convex_hull_support_hill_climb.sv
// A command takes one transfer in and gives one result transfer out. A triangle
// makes six links, each reading the count and then scanning the list one entry
// per cycle. A query visits each neighbour through list read, position read,
// multiply and compare steps, and each pass opens with start, count and pass
// states, over as many passes as the climb needs; the single-port position and
// list memories make these steps run one after another. After reset a clearing
// pass over all MAX_VERTICES entries zeroes the counts before input is taken.
// depends on chsh_pkg and chsh_dot
`default_nettype none
module convex_hull_support_hill_climb #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_DEGREE   = 16,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    command,
    input  wire logic [7:0]                    vertex_id,
    input  wire logic signed [COORD_BITS-1:0]  pos_x,
    input  wire logic signed [COORD_BITS-1:0]  pos_y,
    input  wire logic signed [COORD_BITS-1:0]  pos_z,
    input  wire logic [7:0]                    corner_a,
    input  wire logic [7:0]                    corner_b,
    input  wire logic [7:0]                    corner_c,
    input  wire logic signed [COORD_BITS-1:0]  dir_x,
    input  wire logic signed [COORD_BITS-1:0]  dir_y,
    input  wire logic signed [COORD_BITS-1:0]  dir_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic [7:0]                         support_id,
    output logic signed [COORD_BITS-1:0]       support_x,
    output logic signed [COORD_BITS-1:0]       support_y,
    output logic signed [COORD_BITS-1:0]       support_z
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_DEGREE);
    // width leaves codes above MAX_DEGREE; the all-ones code marks the count-latch cycle
    localparam int NW = $clog2(MAX_DEGREE + 2);
    localparam int PW = 3 * COORD_BITS;
    localparam int LD = MAX_VERTICES * (1 << DW);
    localparam int LW = VW + DW;
    localparam int XW = 2 * COORD_BITS + 2;

    // memories
    logic [PW-1:0] pos_mem [MAX_VERTICES];
    logic [VW-1:0] lst_mem [LD];
    logic [NW-1:0] cnt_mem [MAX_VERTICES];
    logic [PW-1:0] pos_rd;
    logic [VW-1:0] lst_rd;
    logic [NW-1:0] cnt_rd;

    chsh_pkg::state_t state_reg, state_next;

    logic [VW-1:0]          clr_reg, clr_next;
    logic [2:0]             lk_reg, lk_next;
    logic [VW-1:0]          lk_from, lk_to;
    logic [NW-1:0]          n_reg, n_next;
    logic [NW-1:0]          k_reg, k_next;
    logic                   full_reg, full_next;
    logic                   moved_reg, moved_next;
    logic [VW-1:0]          best_reg, best_next;
    logic [VW-1:0]          start_reg, start_next;
    logic [VW-1:0]          cand_reg, cand_next;
    logic signed [XW-1:0]   bdot_reg, bdot_next;
    logic                   have_reg, have_next;
    logic [VW-1:0]          a_reg, b_reg, c_reg;
    logic signed [COORD_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic [1:0]             st_reg, st_next;
    logic [7:0]             sid_reg, sid_next;
    logic [PW-1:0]          spos_reg, spos_next;
    logic                   ov_reg, ov_next;

    logic signed [XW-1:0]   dot;
    logic                   accept;

    // memory control
    logic          pos_we, cnt_we, lst_we;
    logic [VW-1:0] pos_addr, cnt_addr;
    logic [LW-1:0] lst_addr;
    logic [PW-1:0] pos_wd;
    logic [NW-1:0] cnt_wd;
    logic [VW-1:0] lst_wd;

    assign accept = in_valid && in_ready;

    chsh_dot #(.CW(COORD_BITS)) u_dot (
        .clk(clk),
        .px(pos_rd[PW-1 -: COORD_BITS]),
        .py(pos_rd[2*COORD_BITS-1 -: COORD_BITS]),
        .pz(pos_rd[COORD_BITS-1:0]),
        .dx(dx_reg), .dy(dy_reg), .dz(dz_reg),
        .dot(dot)
    );

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_addr] <= pos_wd;
        end
        pos_rd <= pos_mem[pos_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lst_we)
        begin
            lst_mem[lst_addr] <= lst_wd;
        end
        lst_rd <= lst_mem[lst_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_addr] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cnt_addr];
    end

    // link pair for each of the six steps
    always_comb
    begin
        case (lk_reg)
            3'd0:    begin lk_from = a_reg; lk_to = b_reg; end
            3'd1:    begin lk_from = a_reg; lk_to = c_reg; end
            3'd2:    begin lk_from = b_reg; lk_to = a_reg; end
            3'd3:    begin lk_from = b_reg; lk_to = c_reg; end
            3'd4:    begin lk_from = c_reg; lk_to = a_reg; end
            default: begin lk_from = c_reg; lk_to = b_reg; end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        lk_next = lk_reg;
        n_next = n_reg;
        k_next = k_reg;
        full_next = full_reg;
        moved_next = moved_reg;
        best_next = best_reg;
        start_next = start_reg;
        cand_next = cand_reg;
        bdot_next = bdot_reg;
        have_next = have_reg;
        st_next = st_reg;
        sid_next = sid_reg;
        spos_next = spos_reg;
        ov_next = ov_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            chsh_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == VW'(MAX_VERTICES - 1))
                begin
                    state_next = chsh_pkg::S_IDLE;
                end
            end
            chsh_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    st_next = chsh_pkg::ST_OK;
                    sid_next = '0;
                    spos_next = '0;
                    full_next = 1'b0;
                    lk_next = '0;
                    state_next = chsh_pkg::S_OUT;
                    case (chsh_pkg::cmd_t'(command))
                        chsh_pkg::CMD_TRI:
                        begin
                            if (32'(corner_a) < MAX_VERTICES && 32'(corner_b) < MAX_VERTICES
                                && 32'(corner_c) < MAX_VERTICES)
                            begin
                                state_next = chsh_pkg::S_LINK_CNT;
                            end
                        end
                        chsh_pkg::CMD_QUERY:
                        begin
                            best_next = '0;
                            have_next = 1'b0;
                            state_next = chsh_pkg::S_Q_START;
                        end
                        default: ;
                    endcase
                end
            end
            chsh_pkg::S_LINK_CNT:
            begin
                // count read issued; skip self links
                if (lk_from == lk_to)
                begin
                    state_next = chsh_pkg::S_LINK_DONE;
                end
                else
                begin
                    state_next = chsh_pkg::S_LINK_SCAN;
                    k_next = '0;
                    n_next = '1;
                end
            end
            chsh_pkg::S_LINK_SCAN:
            begin
                // first cycle latches count; later cycles compare list entry k-1
                if (n_reg == '1)
                begin
                    n_next = (cnt_rd > NW'(MAX_DEGREE)) ? NW'(MAX_DEGREE) : cnt_rd;
                    k_next = '0;
                end
                else
                begin
                    if (k_reg != '0 && lst_rd == lk_to)
                    begin
                        state_next = chsh_pkg::S_LINK_DONE;
                        n_next = '0;
                    end
                    else if (k_reg == n_reg)
                    begin
                        if (n_reg >= NW'(MAX_DEGREE))
                        begin
                            full_next = 1'b1;
                        end
                        state_next = chsh_pkg::S_LINK_DONE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            chsh_pkg::S_LINK_DONE:
            begin
                if (lk_reg == 3'd5)
                begin
                    st_next = full_next ? chsh_pkg::ST_FULL : chsh_pkg::ST_OK;
                    state_next = chsh_pkg::S_OUT;
                end
                else
                begin
                    lk_next = lk_reg + 1'b1;
                    state_next = chsh_pkg::S_LINK_CNT;
                end
            end
            chsh_pkg::S_Q_START:
            begin
                // position of best read issued
                start_next = best_reg;
                moved_next = 1'b0;
                k_next = '0;
                state_next = chsh_pkg::S_Q_CNT;
            end
            chsh_pkg::S_Q_CNT:
            begin
                // pos_rd valid now, count read issued; dot next cycle
                state_next = chsh_pkg::S_Q_PASS;
            end
            chsh_pkg::S_Q_PASS:
            begin
                if (!have_reg)
                begin
                    bdot_next = dot;
                    have_next = 1'b1;
                end
                n_next = (cnt_rd > NW'(MAX_DEGREE)) ? NW'(MAX_DEGREE) : cnt_rd;
                state_next = chsh_pkg::S_Q_NBR;
                if (cnt_rd == '0)
                begin
                    state_next = chsh_pkg::S_Q_OUT;
                end
            end
            chsh_pkg::S_Q_NBR:
            begin
                state_next = chsh_pkg::S_Q_POS;
            end
            chsh_pkg::S_Q_POS:
            begin
                cand_next = lst_rd;
                state_next = chsh_pkg::S_Q_MUL;
            end
            chsh_pkg::S_Q_MUL:
            begin
                state_next = chsh_pkg::S_Q_CMP;
            end
            chsh_pkg::S_Q_CMP:
            begin
                if (dot > bdot_reg)
                begin
                    bdot_next = dot;
                    best_next = cand_reg;
                    moved_next = 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == n_reg)
                begin
                    state_next = (dot > bdot_reg || moved_reg) ? chsh_pkg::S_Q_START
                                                                : chsh_pkg::S_Q_OUT;
                end
                else
                begin
                    state_next = chsh_pkg::S_Q_NBR;
                end
            end
            chsh_pkg::S_Q_OUT:
            begin
                // position of best read issued in this state
                st_next = chsh_pkg::ST_SUPPORT;
                state_next = chsh_pkg::S_OUT;
            end
            chsh_pkg::S_OUT:
            begin
                if (st_reg == chsh_pkg::ST_SUPPORT)
                begin
                    sid_next = 8'(best_reg);
                    spos_next = pos_rd;
                end
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    state_next = chsh_pkg::S_IDLE;
                end
            end
            default: state_next = chsh_pkg::S_IDLE;
        endcase
    end

    // memory access per state
    always_comb
    begin
        pos_we = 1'b0;
        cnt_we = 1'b0;
        lst_we = 1'b0;
        pos_addr = best_reg;
        cnt_addr = lk_from;
        lst_addr = {lk_from, k_reg[DW-1:0]};
        pos_wd = {pos_x, pos_y, pos_z};
        cnt_wd = '0;
        lst_wd = lk_to;
        case (state_reg)
            chsh_pkg::S_CLEAR:
            begin
                cnt_we = 1'b1;
                cnt_addr = clr_reg;
            end
            chsh_pkg::S_IDLE:
            begin
                if (accept && chsh_pkg::cmd_t'(command) == chsh_pkg::CMD_LOAD
                    && 32'(vertex_id) < MAX_VERTICES)
                begin
                    pos_we = 1'b1;
                    pos_addr = VW'(vertex_id);
                end
            end
            chsh_pkg::S_LINK_SCAN:
            begin
                if (n_reg != '1 && k_reg == n_reg && n_reg < NW'(MAX_DEGREE)
                    && !(k_reg != '0 && lst_rd == lk_to))
                begin
                    lst_we = 1'b1;
                    lst_addr = {lk_from, n_reg[DW-1:0]};
                    cnt_we = 1'b1;
                    cnt_wd = n_reg + 1'b1;
                end
            end
            chsh_pkg::S_Q_START, chsh_pkg::S_Q_CNT, chsh_pkg::S_Q_PASS:
            begin
                cnt_addr = best_reg;
            end
            chsh_pkg::S_Q_NBR:
            begin
                lst_addr = {start_reg, k_reg[DW-1:0]};
            end
            chsh_pkg::S_Q_POS:
            begin
                pos_addr = lst_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chsh_pkg::S_CLEAR;
            clr_reg <= '0;
            ov_reg <= 1'b0;
            lk_reg <= '0;
            n_reg <= '0;
            k_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            ov_reg <= ov_next;
            lk_reg <= lk_next;
            n_reg <= n_next;
            k_reg <= k_next;
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        full_reg <= full_next;
        moved_reg <= moved_next;
        best_reg <= best_next;
        start_reg <= start_next;
        cand_reg <= cand_next;
        bdot_reg <= bdot_next;
        st_reg <= st_next;
        sid_reg <= sid_next;
        spos_reg <= spos_next;
        if (accept)
        begin
            a_reg <= VW'(corner_a);
            b_reg <= VW'(corner_b);
            c_reg <= VW'(corner_c);
            dx_reg <= dir_x;
            dy_reg <= dir_y;
            dz_reg <= dir_z;
        end
    end

    assign in_ready = (state_reg == chsh_pkg::S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign status = st_reg;
    assign support_id = sid_reg;
    assign support_x = spos_reg[PW-1 -: COORD_BITS];
    assign support_y = spos_reg[2*COORD_BITS-1 -: COORD_BITS];
    assign support_z = spos_reg[COORD_BITS-1:0];

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == chsh_pkg::S_IDLE)
        else $error("transfer taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped");
    a_no_write_query: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == chsh_pkg::S_Q_CMP |-> !lst_we && !pos_we)
        else $error("memory write during query");
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for convex_hull_support_hill_climb
// depends on chsh_pkg and the block's rtl; directed and random load/triangle/query traffic
`default_nettype none
module tb_top;
    typedef struct {
        chsh_pkg::cmd_t    cmd;
        logic [7:0]        vid;
        logic signed [15:0] px, py, pz;
        logic [7:0]        ca, cb, cc;
        logic signed [15:0] dx, dy, dz;
    } hull_cmd_t;

    typedef struct {
        chsh_pkg::status_t st;
        logic [7:0]        id;
        logic signed [15:0] sx, sy, sz;
    } hull_res_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [1:0] command, status;
    logic [7:0] vertex_id, corner_a, corner_b, corner_c, support_id;
    logic signed [15:0] pos_x, pos_y, pos_z, dir_x, dir_y, dir_z;
    logic signed [15:0] support_x, support_y, support_z;

    convex_hull_support_hill_climb dut (.*);

    hull_cmd_t pending[$];
    hull_res_t expected_res[$];
    int errors = 0;
    int results_seen = 0;

    // predictor copy of the hull
    logic signed [15:0] vx[256], vy[256], vz[256];
    logic [7:0] nbr_list[256][16];
    int nbr_cnt[256];

    // generator side bookkeeping: which ids hold a position
    bit loaded[256];
    int loaded_ids[$];

    function automatic longint hull_dot(int v, hull_cmd_t c);
        return longint'(vx[v]) * c.dx + longint'(vy[v]) * c.dy + longint'(vz[v]) * c.dz;
    endfunction

    function automatic bit link(int from, int to);
        if (from == to) return 0;
        for (int k = 0; k < nbr_cnt[from]; k++)
            if (nbr_list[from][k] == to[7:0]) return 0;
        if (nbr_cnt[from] >= 16) return 1;
        nbr_list[from][nbr_cnt[from]] = to[7:0];
        nbr_cnt[from]++;
        return 0;
    endfunction

    function automatic hull_res_t predict_hull(hull_cmd_t c);
        hull_res_t r;
        bit full, moved;
        int best, start;
        longint bd, cd;
        r = '{chsh_pkg::ST_OK, 8'd0, 16'sd0, 16'sd0, 16'sd0};
        case (c.cmd)
            chsh_pkg::CMD_LOAD:
            begin
                vx[c.vid] = c.px;
                vy[c.vid] = c.py;
                vz[c.vid] = c.pz;
            end
            chsh_pkg::CMD_TRI:
            begin
                full = 0;
                full |= link(int'(c.ca), int'(c.cb));
                full |= link(int'(c.ca), int'(c.cc));
                full |= link(int'(c.cb), int'(c.ca));
                full |= link(int'(c.cb), int'(c.cc));
                full |= link(int'(c.cc), int'(c.ca));
                full |= link(int'(c.cc), int'(c.cb));
                r.st = full ? chsh_pkg::ST_FULL : chsh_pkg::ST_OK;
            end
            chsh_pkg::CMD_QUERY:
            begin
                best = 0;
                bd = hull_dot(0, c);
                moved = 1;
                while (moved)
                begin
                    moved = 0;
                    start = best;
                    for (int k = 0; k < nbr_cnt[start]; k++)
                    begin
                        cd = hull_dot(int'(nbr_list[start][k]), c);
                        if (cd > bd)
                        begin
                            best = int'(nbr_list[start][k]);
                            bd = cd;
                            moved = 1;
                        end
                    end
                end
                r = '{chsh_pkg::ST_SUPPORT, best[7:0], vx[best], vy[best], vz[best]};
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic hull_cmd_t blank_cmd(chsh_pkg::cmd_t k);
        hull_cmd_t c;
        c.cmd = k;
        c.vid = 8'($urandom);
        c.px = 16'($urandom);
        c.py = 16'($urandom);
        c.pz = 16'($urandom);
        c.ca = 8'($urandom);
        c.cb = 8'($urandom);
        c.cc = 8'($urandom);
        c.dx = 16'($urandom);
        c.dy = 16'($urandom);
        c.dz = 16'($urandom);
        return c;
    endfunction

    task automatic push_load(int id, logic signed [15:0] x, y, z);
        hull_cmd_t c;
        c = blank_cmd(chsh_pkg::CMD_LOAD);
        c.vid = id[7:0];
        c.px = x;
        c.py = y;
        c.pz = z;
        if (!loaded[id]) loaded_ids = {loaded_ids, id};
        loaded[id] = 1;
        pending = {pending, c};
    endtask

    task automatic push_tri(int a, int b, int cc);
        hull_cmd_t c;
        c = blank_cmd(chsh_pkg::CMD_TRI);
        c.ca = a[7:0];
        c.cb = b[7:0];
        c.cc = cc[7:0];
        pending = {pending, c};
    endtask

    task automatic push_query(logic signed [15:0] x, y, z);
        hull_cmd_t c;
        c = blank_cmd(chsh_pkg::CMD_QUERY);
        c.dx = x;
        c.dy = y;
        c.dz = z;
        pending = {pending, c};
    endtask

    function automatic int pick_corner();
        // mostly a small cluster so adjacency lists fill up
        if ($urandom_range(3, 0) != 0 && loaded_ids.size() > 24)
            return loaded_ids[$urandom_range(23, 0)];
        return loaded_ids[$urandom_range(loaded_ids.size() - 1, 0)];
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        int k;
        rst_n = 0;
        foreach (nbr_cnt[i]) nbr_cnt[i] = 0;
        // directed: extremes, repeated corners, reload, unused command
        push_load(0, 16'sh0000, 16'sh0000, 16'sh0000);
        push_load(255, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_load(170, -16'sh8000, -16'sh8000, -16'sh8000);
        push_load(85, 16'sh7fff, -16'sh8000, 16'sh0001);
        push_query(16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_tri(0, 255, 170);
        push_tri(0, 0, 85);
        push_tri(85, 85, 85);
        push_tri(0, 255, 170);
        push_query(16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_query(-16'sh8000, -16'sh8000, -16'sh8000);
        push_query(16'sh0000, 16'sh0000, 16'sh0000);
        push_query(16'sh0001, -16'sh8000, 16'sh0000);
        push_load(255, -16'sh0100, 16'sh0100, 16'sh0000);
        push_query(16'sh7fff, 16'sh7fff, 16'sh7fff);
        pending = {pending, blank_cmd(chsh_pkg::CMD_NONE)};
        for (int i = 1; i <= 20; i++)
        begin
            push_load(i, 16'($urandom), 16'($urandom), 16'($urandom));
            push_tri(0, i, 85);
        end
        push_query(16'sh0100, 16'sh0000, 16'sh0000);
        // random traffic
        for (int i = 0; i < 1350; i++)
        begin
            k = $urandom_range(99, 0);
            if (k < 30)
                push_load($urandom_range(255, 0), 16'($urandom), 16'($urandom),
                          16'($urandom));
            else if (k < 68)
                push_tri(pick_corner(), pick_corner(), pick_corner());
            else if (k < 97)
            begin
                if ($urandom_range(7, 0) == 0)
                    push_query($urandom_range(1, 0) ? 16'sh7fff : -16'sh8000,
                               $urandom_range(1, 0) ? 16'sh7fff : -16'sh8000,
                               $urandom_range(1, 0) ? 16'sh7fff : -16'sh8000);
                else
                    push_query(16'($urandom), 16'($urandom), 16'($urandom));
            end
            else
                pending = {pending, blank_cmd(chsh_pkg::CMD_NONE)};
        end
        repeat (12) @(posedge clk);
        rst_n <= 1;
        wait (pending.size() == 0 && expected_res.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_res.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // driver: bursts of transfers with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        bit offer;
        hull_cmd_t c;
        hull_res_t r;
        if (!rst_n)
        begin
            in_valid <= 0;
            command <= '0;
            vertex_id <= '0;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
            corner_a <= '0;
            corner_b <= '0;
            corner_c <= '0;
            dir_x <= '0;
            dir_y <= '0;
            dir_z <= '0;
        end
        else
        begin
            offer = in_valid;
            if (in_valid && in_ready)
            begin
                r = predict_hull(pending.pop_front());
                expected_res = {expected_res, r};
                offer = 0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() > 0)
                begin
                    c = pending[0];
                    command <= c.cmd;
                    vertex_id <= c.vid;
                    pos_x <= c.px;
                    pos_y <= c.py;
                    pos_z <= c.pz;
                    corner_a <= c.ca;
                    corner_b <= c.cb;
                    corner_c <= c.cc;
                    dir_x <= c.dx;
                    dir_y <= c.dy;
                    dir_z <= c.dz;
                    offer = 1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(30, 1);
                        gap_left = $urandom_range(2, 0) == 0 ? 0 : $urandom_range(40, 1);
                    end
                    else
                        burst_left--;
                end
            end
            in_valid <= offer;
        end
    end

    // receiver: stall pattern plus one long hold-off
    int stall_mode = 0, mode_left = 0, hold_left = 0;
    bit held = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 0;
        else
        begin
            if (!held && results_seen == 300)
            begin
                held = 1;
                hold_left = 3000;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(2, 0);
                mode_left = $urandom_range(80, 10);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 0;
            end
            else if (stall_mode == 0)
                out_ready <= 1;
            else if (stall_mode == 1)
                out_ready <= 1'($urandom_range(1, 0));
            else
                out_ready <= $urandom_range(4, 0) == 0;
        end
    end

    // monitor: compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin
        hull_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_res.size() == 0)
                report("unexpected result", 16'(status), 16'd0);
            else
            begin
                e = expected_res.pop_front();
                if (status !== e.st) report("status", 16'(status), 16'(e.st));
                if (support_id !== e.id) report("support_id", 16'(support_id), 16'(e.id));
                if (support_x !== e.sx) report("support_x", support_x, e.sx);
                if (support_y !== e.sy) report("support_y", support_y, e.sy);
                if (support_z !== e.sz) report("support_z", support_z, e.sz);
            end
        end
    end
endmodule
`default_nettype wire
